@@ hdl/vnorm_pkg.sv @@
// ----------------------------------------------------------------------------
// vnorm_pkg: shared types and constants
// Widths, depth and the controller state type of the vector normaliser.
// ----------------------------------------------------------------------------
package vnorm_pkg;

  localparam int unsigned MaxLen    = 64;
  localparam int unsigned ElemWidth = 16;
  localparam int unsigned AddrWidth = $clog2(MaxLen);
  localparam int unsigned CntWidth  = $clog2(MaxLen + 1);
  localparam int unsigned SumWidth  = 2 * ElemWidth + CntWidth - 2;
  localparam int unsigned MagWidth  = ElemWidth + 3;
  localparam int unsigned IdxWidth  = 6;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_SQRT,
    ST_READ,
    ST_DIV,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic                        start;
    logic [ElemWidth-1:0]        dividend;
    logic [MagWidth-1:0]         divisor;
  } div_req_t;

  typedef struct packed {
    logic                        done;
    logic [ElemWidth-1:0]        quotient;
  } div_rsp_t;

endpackage

@@ hdl/vnorm_store.sv @@
// ----------------------------------------------------------------------------
// vnorm_store: element memory
// Synchronous single-port-write, single-read memory with registered read data.
// ----------------------------------------------------------------------------
module vnorm_store (
  input  logic                                clk_i,
  input  logic                                we_i,
  input  logic [vnorm_pkg::AddrWidth-1:0]     waddr_i,
  input  logic [vnorm_pkg::ElemWidth-1:0]     wdata_i,
  input  logic [vnorm_pkg::AddrWidth-1:0]     raddr_i,
  output logic [vnorm_pkg::ElemWidth-1:0]     rdata_o
);

  logic [vnorm_pkg::ElemWidth-1:0] mem_q [vnorm_pkg::MaxLen];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

@@ hdl/vnorm_sqrt.sv @@
// ----------------------------------------------------------------------------
// vnorm_sqrt: iterative integer square root
// One root bit per cycle, restoring digit method.
// ----------------------------------------------------------------------------
module vnorm_sqrt (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic [vnorm_pkg::SumWidth-1:0]    radicand_i,
  output logic                              done_o,
  output logic [vnorm_pkg::MagWidth-1:0]    root_o
);

  localparam int unsigned Steps = (vnorm_pkg::SumWidth + 1) / 2;
  localparam int unsigned RemW  = vnorm_pkg::SumWidth + 2;
  localparam int unsigned StepW = $clog2(Steps + 1);

  logic [2*Steps-1:0]            x_q, x_d;
  logic [RemW-1:0]               rem_q, rem_d;
  logic [vnorm_pkg::MagWidth-1:0] root_q, root_d;
  logic [StepW-1:0]              cnt_q, cnt_d;
  logic                          busy_q, busy_d;
  logic                          busy_dly_q;
  logic [RemW-1:0]               trial;
  logic [RemW-1:0]               test;

  always_comb begin
    x_d    = x_q;
    rem_d  = rem_q;
    root_d = root_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    trial  = {rem_q[RemW-3:0], x_q[2*Steps-1 -: 2]};
    test   = {(RemW-2)'(root_q), 2'b01};
    if (start_i) begin
      x_d    = (2*Steps)'(radicand_i);
      rem_d  = '0;
      root_d = '0;
      cnt_d  = StepW'(Steps);
      busy_d = 1'b1;
    end else if (busy_q) begin
      x_d = x_q << 2;
      if (trial >= test) begin
        rem_d  = trial - test;
        root_d = {root_q[vnorm_pkg::MagWidth-2:0], 1'b1};
      end else begin
        rem_d  = trial;
        root_d = {root_q[vnorm_pkg::MagWidth-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == StepW'(1)) begin
        busy_d = 1'b0;
      end
    end
  end

  assign root_o = root_q;

  // done pulses in the same cycle that the last digit lands in root_q
  assign done_o = busy_dly_q & ~busy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q     <= 1'b0;
      busy_dly_q <= 1'b0;
      cnt_q      <= '0;
    end else begin
      busy_q     <= busy_d;
      busy_dly_q <= busy_q;
      cnt_q      <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q    <= x_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

endmodule

@@ hdl/vnorm_div.sv @@
// ----------------------------------------------------------------------------
// vnorm_div: iterative Q-format divider
// |element| << (ElemWidth-1) / magnitude, one quotient bit per cycle,
// sign restored and saturated at the end.
// ----------------------------------------------------------------------------
module vnorm_div (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  vnorm_pkg::div_req_t   req_i,
  output vnorm_pkg::div_rsp_t   rsp_o
);

  localparam int unsigned QW    = 2 * vnorm_pkg::ElemWidth - 1;
  localparam int unsigned RW    = vnorm_pkg::MagWidth + 1;
  localparam int unsigned StepW = $clog2(QW + 1);
  localparam int unsigned EW    = vnorm_pkg::ElemWidth;

  logic [QW-1:0]    num_q, num_d;
  logic [RW-1:0]    rem_q, rem_d;
  logic [vnorm_pkg::MagWidth-1:0] den_q, den_d;
  logic             neg_q, neg_d;
  logic [StepW-1:0] cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic             fin_q, fin_d;
  logic [RW-1:0]    trial;
  logic [EW-1:0]    mag_e;
  logic [QW-1:0]    q;

  always_comb begin
    num_d  = num_q;
    rem_d  = rem_q;
    den_d  = den_q;
    neg_d  = neg_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    fin_d  = 1'b0;
    mag_e  = req_i.dividend[EW-1] ? EW'(-req_i.dividend) : req_i.dividend;
    trial  = {rem_q[RW-2:0], num_q[QW-1]};
    if (req_i.start) begin
      num_d  = {mag_e, (EW-1)'(0)};
      rem_d  = '0;
      den_d  = req_i.divisor;
      neg_d  = req_i.dividend[EW-1];
      cnt_d  = StepW'(QW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= RW'(den_q)) begin
        rem_d = trial - RW'(den_q);
        num_d = {num_q[QW-2:0], 1'b1};
      end else begin
        rem_d = trial;
        num_d = {num_q[QW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == StepW'(1)) begin
        busy_d = 1'b0;
        fin_d  = 1'b1;
      end
    end
  end

  // num_q now holds the quotient; saturate and apply sign
  always_comb begin
    q = num_q;
    rsp_o.done = fin_q;
    if (neg_q) begin
      rsp_o.quotient = (q > QW'(1 << (EW-1))) ? {1'b1, (EW-1)'(0)} : EW'(-q);
    end else begin
      rsp_o.quotient = (q > QW'((1 << (EW-1)) - 1)) ? {1'b0, {(EW-1){1'b1}}}
                                                     : EW'(q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      fin_q  <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      fin_q  <= fin_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
    den_q <= den_d;
    neg_q <= neg_d;
  end

endmodule

@@ hdl/vector_normalize_unit.sv @@
// ----------------------------------------------------------------------------
// vector_normalize_unit: streamed Euclidean vector normaliser
// Loads signed Q1.15 elements, then emits each divided by the floored length.
// ----------------------------------------------------------------------------
// Usage:
//  s_axis carries one element per beat (tdata = element, tlast = end of
//  vector), one beat per cycle. Elements go to a 64-entry memory and their
//  squares are accumulated. Beyond 64 elements a beat is dropped but its
//  tlast still closes the vector.
//  After the tlast beat s_axis_tready stays low until the last result is
//  taken. The square root runs first (start, 19 digits, done); each
//  element is then read, divided (start, 31 digits, done) and output,
//  and the next element is read only once its result has been taken.
//  A zero length skips the divider: results zero, tuser set.
//  m_axis emits one beat per stored element, in order, tlast on the last.
//  A stalled receiver simply holds the output beat; nothing is lost.
//  Reset clears the sum, count and controller; memory contents are not
//  cleared, never-written entries are never read.
// ----------------------------------------------------------------------------
module vector_normalize_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // [15:0] element
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,  // [15:0] normalized, [21:16] index,
                                     // [40:22] magnitude, [47:41] zero
  output logic        m_axis_tuser,  // [0] zero_length
  output logic        m_axis_tlast
);

  localparam int unsigned AW = vnorm_pkg::AddrWidth;
  localparam int unsigned CW = vnorm_pkg::CntWidth;
  localparam int unsigned EW = vnorm_pkg::ElemWidth;
  localparam int unsigned MW = vnorm_pkg::MagWidth;
  localparam int unsigned SW = vnorm_pkg::SumWidth;

  vnorm_pkg::state_e state_q, state_d;
  logic [CW-1:0] count_q, count_d;
  logic [SW-1:0] sum_q, sum_d;
  logic [AW-1:0] rd_q, rd_d;
  logic [MW-1:0] mag_q, mag_d;
  logic [EW-1:0] res_q, res_d;
  logic          last_q, last_d;
  logic [AW-1:0] oidx_q, oidx_d;
  logic          sqrt_go_q, sqrt_go_d;
  logic          div_go_q, div_go_d;

  logic          acc;
  logic          store_we;
  logic [EW-1:0] abs_e;
  logic [2*EW-1:0] sq_e;
  logic          sqrt_done;
  logic [MW-1:0] root;
  logic [EW-1:0] rdata;
  vnorm_pkg::div_req_t div_req;
  vnorm_pkg::div_rsp_t div_rsp;

  assign acc      = s_axis_tvalid & s_axis_tready;
  assign store_we = acc & (count_q < CW'(vnorm_pkg::MaxLen));
  assign abs_e    = s_axis_tdata[EW-1] ? EW'(-s_axis_tdata) : s_axis_tdata;
  assign sq_e     = abs_e * abs_e;

  vnorm_store u_store (
    .clk_i   (clk_i),
    .we_i    (store_we),
    .waddr_i (count_q[AW-1:0]),
    .wdata_i (s_axis_tdata),
    .raddr_i (rd_q),
    .rdata_o (rdata)
  );

  // started the cycle after the tlast beat, once the sum has settled
  vnorm_sqrt u_sqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (sqrt_go_q),
    .radicand_i (sum_q),
    .done_o     (sqrt_done),
    .root_o     (root)
  );

  vnorm_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  always_comb begin
    state_d       = state_q;
    count_d       = count_q;
    sum_d         = sum_q;
    rd_d          = rd_q;
    mag_d         = mag_q;
    res_d         = res_q;
    last_d        = last_q;
    oidx_d        = oidx_q;
    sqrt_go_d     = 1'b0;
    div_go_d      = 1'b0;
    s_axis_tready = 1'b0;
    m_axis_tvalid = 1'b0;
    // read data is valid in the first DIV cycle
    div_req.start    = div_go_q & (mag_q != '0);
    div_req.dividend = rdata;
    div_req.divisor  = mag_q;
    unique case (state_q)
      vnorm_pkg::ST_LOAD: begin
        s_axis_tready = 1'b1;
        if (store_we) begin
          count_d = count_q + 1'b1;
          sum_d   = sum_q + SW'(sq_e);
        end
        if (acc && s_axis_tlast) begin
          state_d   = vnorm_pkg::ST_SQRT;
          sqrt_go_d = 1'b1;
        end
      end
      vnorm_pkg::ST_SQRT: begin
        if (sqrt_done) begin
          mag_d   = root;
          rd_d    = '0;
          state_d = vnorm_pkg::ST_READ;
        end
      end
      vnorm_pkg::ST_READ: begin
        div_go_d = 1'b1;
        state_d  = vnorm_pkg::ST_DIV;
      end
      vnorm_pkg::ST_DIV: begin
        if (mag_q == '0) begin
          res_d   = '0;
          last_d  = (CW'(rd_q) + 1'b1 == count_q);
          oidx_d  = rd_q;
          state_d = vnorm_pkg::ST_OUT;
        end else if (div_rsp.done) begin
          res_d   = div_rsp.quotient;
          last_d  = (CW'(rd_q) + 1'b1 == count_q);
          oidx_d  = rd_q;
          state_d = vnorm_pkg::ST_OUT;
        end
      end
      vnorm_pkg::ST_OUT: begin
        m_axis_tvalid = 1'b1;
        if (m_axis_tready) begin
          if (last_q) begin
            state_d = vnorm_pkg::ST_LOAD;
            count_d = '0;
            sum_d   = '0;
          end else begin
            rd_d    = rd_q + 1'b1;
            state_d = vnorm_pkg::ST_READ;
          end
        end
      end
      default: state_d = vnorm_pkg::ST_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= vnorm_pkg::ST_LOAD;
      count_q   <= '0;
      sum_q     <= '0;
      rd_q      <= '0;
      sqrt_go_q <= 1'b0;
      div_go_q  <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      sum_q     <= sum_d;
      rd_q      <= rd_d;
      sqrt_go_q <= sqrt_go_d;
      div_go_q  <= div_go_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q  <= mag_d;
    res_q  <= res_d;
    last_q <= last_d;
    oidx_q <= oidx_d;
  end

  assign m_axis_tdata = {7'd0, mag_q, oidx_q, res_q};
  assign m_axis_tuser = (mag_q == '0);
  assign m_axis_tlast = last_q;

`ifndef SYNTHESIS
  a_no_in_while_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !s_axis_tready) else $error("input taken while emitting");
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(vnorm_pkg::MaxLen)) else $error("count overflow");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output beat changed under stall");
`endif

endmodule
